FILE: rtl/core/lzssd_pkg.sv
// Package for the LZSS stream decompressor core.
// Holds the fixed format constants and result status codes; no dependencies.
package lzssd_pkg;

   localparam logic [31:0] LZSS_ID        = 32'h5353_5A4C;
   localparam int          HIST_DEPTH     = 4096;
   localparam int          HIST_AW        = 12;
   localparam int          MATCH_LEN_W    = 4;

   localparam logic [1:0]  STATUS_DATA = 2'd0;
   localparam logic [1:0]  STATUS_DONE = 2'd1;
   localparam logic [1:0]  STATUS_FAIL = 2'd2;

endpackage

FILE: rtl/core/lzssd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lzssd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lzss_stream_decompressor_core.sv
// LZSS stream decompressor core: header check, flag/token decode, history copy.
// Depends on lzssd_pkg and lzssd_ram (4096 x 8 history memory).
//
// Header, flag and literal beats: the result (if any) sits in
//   the output register the cycle after the accepting edge.
// Match beats: the input stalls while the copy runs: the accepting edge, a read setup,
//   then one history byte per cycle while the output is free, set by the single read port.
// Reset: control state clears, the decoder stays stopped until a beat with start set,
//   buf_size returns to all ones. History memory is not cleared and needs no sweep.
module lzss_stream_decompressor_core
   import lzssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration: buf_size
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   // compressed input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] start_req
   // decompressed output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [39:8] total_len
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last
);

   typedef enum logic {ST_IDLE, ST_COPY} state_type;
   typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_MATCH2} phase_type;

   // control state
   state_type            state_ff,    state_in;
   phase_type            phase_ff,    phase_in;
   logic                 stopped_ff,  stopped_in;
   logic [HIST_AW-1:0]   wp_ff,       wp_in;
   logic [3:0]           hc_ff,       hc_in;
   logic [63:0]          hdr_ff,      hdr_in;
   logic [7:0]           flag_ff,     flag_in;
   logic [2:0]           fidx_ff,     fidx_in;
   logic [7:0]           mhb_ff,      mhb_in;
   logic [31:0]          prod_ff,     prod_in;
   logic [31:0]          buf_size_ff;
   logic [4:0]           rem_ff,      rem_in;
   logic [HIST_AW-1:0]   rd_addr_ff,  rd_addr_in;
   logic                 pend_ff,     pend_in;
   logic                 fwd_ff,      fwd_in;
   logic [7:0]           fwd_data_ff, fwd_data_in;
   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_byte_ff,  out_byte_in;
   logic [1:0]           out_status_ff, out_status_in;
   logic [31:0]          out_len_ff,   out_len_in;
   logic                 out_last_ff,  out_last_in;
   logic                 out_load;

   // values after an optional restart on the current beat
   logic                 start;
   logic                 cur_stopped;
   phase_type            cur_phase;
   logic [HIST_AW-1:0]   cur_wp;
   logic [3:0]           cur_hc;
   logic [63:0]          cur_hdr;
   logic [7:0]           cur_flag;
   logic [2:0]           cur_fidx;
   logic [7:0]           cur_mhb;
   logic [31:0]          cur_prod;

   logic                 req_fire;
   logic                 out_free;
   logic                 emit;
   logic                 issue;
   logic [7:0]           in_b;
   logic [12:0]          pos;
   logic [4:0]           cnt;
   logic [32:0]          sum_lit;
   logic [32:0]          sum_match;
   logic [2:0]           fidx_next;

   // history memory ports
   logic                 ram_we;
   logic [HIST_AW-1:0]   ram_waddr;
   logic [7:0]           ram_wdata;
   logic                 ram_re;
   logic [7:0]           ram_q;
   logic [7:0]           rd_byte;

   lzssd_ram #(
      .WIDTH (8),
      .DEPTH (HIST_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_q)
   );

   // the output register frees up when empty or drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign in_b       = req_tdata;
   assign start      = req_tuser;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_len_ff, out_byte_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   // a start beat wipes the decode state before it is decoded itself
   assign cur_stopped = start ? 1'b0 : stopped_ff;
   assign cur_phase   = start ? PH_FLAG : phase_ff;
   assign cur_wp      = start ? '0 : wp_ff;
   assign cur_hc      = start ? '0 : hc_ff;
   assign cur_hdr     = start ? '0 : hdr_ff;
   assign cur_flag    = start ? '0 : flag_ff;
   assign cur_fidx    = start ? '0 : fidx_ff;
   assign cur_mhb     = start ? '0 : mhb_ff;
   assign cur_prod    = start ? '0 : prod_ff;

   // match fields: 12-bit distance-1, then 4-bit length-1
   assign pos       = {1'b0, cur_mhb, in_b[7:MATCH_LEN_W]} + 13'd1;
   assign cnt       = {1'b0, in_b[MATCH_LEN_W-1:0]} + 5'd1;
   assign sum_lit   = {1'b0, cur_prod} + 33'd1;
   assign sum_match = {1'b0, cur_prod} + 33'(cnt);
   assign fidx_next = cur_fidx + 3'd1;

   // copy pipeline: a read is in flight (pend) until its byte goes out
   assign emit    = (state_ff == ST_COPY) && pend_ff && out_free;
   assign issue   = (state_ff == ST_COPY) && (rem_ff != 5'd0) && (!pend_ff || emit);
   assign rd_byte = fwd_ff ? fwd_data_ff : ram_q;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      stopped_in  = stopped_ff;
      wp_in       = wp_ff;
      hc_in       = hc_ff;
      hdr_in      = hdr_ff;
      flag_in     = flag_ff;
      fidx_in     = fidx_ff;
      mhb_in      = mhb_ff;
      prod_in     = prod_ff;
      rem_in      = rem_ff;
      rd_addr_in  = rd_addr_ff;
      pend_in     = pend_ff;
      out_load    = 1'b0;
      out_byte_in = 8'd0;
      out_status_in = STATUS_DATA;
      out_len_in  = 32'd0;
      out_last_in = 1'b1;
      ram_we      = 1'b0;
      ram_waddr   = cur_wp;
      ram_wdata   = in_b;
      ram_re      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               stopped_in = cur_stopped;
               phase_in   = cur_phase;
               wp_in      = cur_wp;
               hc_in      = cur_hc;
               hdr_in     = cur_hdr;
               flag_in    = cur_flag;
               fidx_in    = cur_fidx;
               mhb_in     = cur_mhb;
               prod_in    = cur_prod;
               if (!cur_stopped) begin
                  if (!cur_hc[3]) begin
                     // header: collect little-endian id and expected size
                     hdr_in[{cur_hc[2:0], 3'b000} +: 8] = in_b;
                     hc_in = cur_hc + 4'd1;
                     if (cur_hc == 4'd7) begin
                        if (hdr_in[31:0] != LZSS_ID || hdr_in[63:32] == 32'd0 ||
                            hdr_in[63:32] > buf_size_ff) begin
                           out_load      = 1'b1;
                           out_status_in = STATUS_FAIL;
                           stopped_in    = 1'b1;
                        end
                     end
                  end else begin
                     unique case (cur_phase)
                        PH_FLAG: begin
                           flag_in  = in_b;
                           phase_in = PH_TOKEN;
                        end
                        PH_TOKEN: begin
                           if (cur_flag[0]) begin
                              mhb_in   = in_b;
                              phase_in = PH_MATCH2;
                           end else if (sum_lit > {1'b0, buf_size_ff}) begin
                              out_load      = 1'b1;
                              out_status_in = STATUS_FAIL;
                              stopped_in    = 1'b1;
                           end else begin
                              // literal: write history and emit
                              prod_in     = sum_lit[31:0];
                              ram_we      = 1'b1;
                              wp_in       = cur_wp + HIST_AW'(1);
                              out_load    = 1'b1;
                              out_byte_in = in_b;
                              flag_in     = cur_flag >> 1;
                              fidx_in     = fidx_next;
                              phase_in    = (fidx_next == 3'd0) ? PH_FLAG : PH_TOKEN;
                           end
                        end
                        default: begin
                           if (in_b[MATCH_LEN_W-1:0] == '0) begin
                              // end token: compare against expected size
                              out_load   = 1'b1;
                              stopped_in = 1'b1;
                              if ({1'b0, cur_prod} == {1'b0, cur_hdr[63:32]}) begin
                                 out_status_in = STATUS_DONE;
                                 out_len_in    = cur_prod;
                              end else begin
                                 out_status_in = STATUS_FAIL;
                              end
                           end else if (32'(pos) > cur_prod ||
                                        sum_match > {1'b0, buf_size_ff}) begin
                              out_load      = 1'b1;
                              out_status_in = STATUS_FAIL;
                              stopped_in    = 1'b1;
                           end else begin
                              // start the copy; flag advances now, no beat comes meanwhile
                              prod_in    = sum_match[31:0];
                              state_in   = ST_COPY;
                              rem_in     = cnt;
                              rd_addr_in = cur_wp - pos[HIST_AW-1:0];
                              pend_in    = 1'b0;
                              flag_in    = cur_flag >> 1;
                              fidx_in    = fidx_next;
                              phase_in   = (fidx_next == 3'd0) ? PH_FLAG : PH_TOKEN;
                           end
                        end
                     endcase
                  end
               end
            end
         end
         ST_COPY: begin
            ram_waddr = wp_ff;
            ram_wdata = rd_byte;
            if (emit) begin
               ram_we      = 1'b1;
               wp_in       = wp_ff + HIST_AW'(1);
               out_load    = 1'b1;
               out_byte_in = rd_byte;
               out_last_in = (rem_ff == 5'd0);
               if (rem_ff == 5'd0) begin
                  state_in = ST_IDLE;
               end
            end
            if (issue) begin
               ram_re     = 1'b1;
               rd_addr_in = rd_addr_ff + HIST_AW'(1);
               rem_in     = rem_ff - 5'd1;
            end
            pend_in = issue ? 1'b1 : (emit ? 1'b0 : pend_ff);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // forward the byte being written when the read hits the same entry
   always_comb begin
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (ram_re) begin
         fwd_in      = ram_we && (ram_waddr == rd_addr_ff);
         fwd_data_in = ram_wdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FLAG;
         stopped_ff   <= 1'b1;
         wp_ff        <= '0;
         hc_ff        <= '0;
         hdr_ff       <= '0;
         flag_ff      <= '0;
         fidx_ff      <= '0;
         mhb_ff       <= '0;
         prod_ff      <= '0;
         buf_size_ff  <= '1;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         stopped_ff   <= stopped_in;
         wp_ff        <= wp_in;
         hc_ff        <= hc_in;
         hdr_ff       <= hdr_in;
         flag_ff      <= flag_in;
         fidx_ff      <= fidx_in;
         mhb_ff       <= mhb_in;
         prod_ff      <= prod_in;
         if (csr_we) begin
            buf_size_ff <= csr_wdata;
         end
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload registers carry no reset
      rd_addr_ff  <= rd_addr_in;
      fwd_data_ff <= fwd_data_in;
      if (out_load) begin
         out_byte_ff   <= out_byte_in;
         out_status_ff <= out_status_in;
         out_len_ff    <= out_len_in;
         out_last_ff   <= out_last_in;
      end
   end

   // a done or fail result stops the decoder
   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_status_in != STATUS_DATA) |=> stopped_ff)
      else $error("end or fail result did not stop the decoder");

   // status results are always the final result of their beat
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_status_ff != STATUS_DATA) |-> out_last_ff)
      else $error("status result without last");

   // never overwrite a history byte still waiting to go out
   a_no_read_overrun: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (!pend_ff || emit))
      else $error("history read issued over a pending byte");

   // remaining copy count lives only inside a copy
   a_rem_in_copy: assert property (@(posedge clock) disable iff (reset)
      (rem_ff != 5'd0) |-> (state_ff == ST_COPY))
      else $error("copy count left over outside a copy");

   // nothing in flight once back in idle
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("history read pending in idle");

endmodule

FILE: test/testbench.sv
// Self-checking bench for lzss_stream_decompressor_core: directed payloads, then random payloads.
// Holds its own decoder to predict every output beat. Depends on lzssd_pkg and the core RTL.
import lzssd_pkg::*;

typedef enum logic [1:0] {WAIT_FLAG, WAIT_TOKEN, WAIT_MATCH2} token_phase_type;

typedef struct {
   logic [7:0]  data;
   logic [1:0]  status;
   logic [31:0] total;
   logic        last;
} result_beat_type;

class decomp_scoreboard;
   logic [7:0]      history [HIST_DEPTH];
   logic [11:0]     wr_ptr;
   logic [3:0]      hdr_cnt;
   logic [63:0]     hdr_shift;
   logic [7:0]      flags;
   logic [2:0]      flag_idx;
   token_phase_type phase;
   logic [7:0]      match_hi;
   logic [32:0]     produced;
   bit              stopped;
   logic [31:0]     buf_size;
   result_beat_type expected_q[$];
   int              mismatches;
   int              checked;
   int              consumed;

   function new();
      restart();
      stopped  = 1'b1;
      buf_size = '1;
   endfunction

   function void restart();
      wr_ptr    = '0;
      hdr_cnt   = '0;
      hdr_shift = '0;
      flags     = '0;
      flag_idx  = '0;
      phase     = WAIT_FLAG;
      match_hi  = '0;
      produced  = '0;
      stopped   = 1'b0;
   endfunction

   function void set_buf_size(logic [31:0] v);
      buf_size = v;
   endfunction

   function void push_beat(logic [7:0] d, logic [1:0] s, logic [31:0] t);
      result_beat_type r;
      r.data   = d;
      r.status = s;
      r.total  = t;
      r.last   = 1'b0;
      expected_q.push_back(r);
   endfunction

   function void fail_stop();
      push_beat(8'h00, STATUS_FAIL, 32'd0);
      stopped = 1'b1;
   endfunction

   function void emit(logic [7:0] b);
      history[wr_ptr] = b;
      wr_ptr = wr_ptr + 12'd1;
      push_beat(b, STATUS_DATA, 32'd0);
   endfunction

   function void next_flag();
      flags    = flags >> 1;
      flag_idx = flag_idx + 3'd1;
      phase    = (flag_idx == 3'd0) ? WAIT_FLAG : WAIT_TOKEN;
   endfunction

   function void decode_byte(logic [7:0] b);
      logic [31:0] exp_size;
      logic [12:0] pos;
      logic [4:0]  cnt;
      logic [11:0] src;
      if (hdr_cnt < 4'd8) begin
         hdr_shift = hdr_shift | (64'(b) << (8 * hdr_cnt));
         hdr_cnt   = hdr_cnt + 4'd1;
         if (hdr_cnt == 4'd8) begin
            exp_size = hdr_shift[63:32];
            if (hdr_shift[31:0] != LZSS_ID || exp_size == 32'd0 || exp_size > buf_size)
               fail_stop();
         end
         return;
      end
      case (phase)
         WAIT_FLAG: begin
            flags = b;
            phase = WAIT_TOKEN;
         end
         WAIT_TOKEN: begin
            if (flags[0]) begin
               match_hi = b;
               phase    = WAIT_MATCH2;
            end else if (produced + 33'd1 > {1'b0, buf_size}) begin
               fail_stop();
            end else begin
               produced = produced + 33'd1;
               emit(b);
               next_flag();
            end
         end
         default: begin
            pos = {1'b0, match_hi, b[7:4]} + 13'd1;
            cnt = {1'b0, b[3:0]} + 5'd1;
            if (cnt == 5'd1) begin
               stopped = 1'b1;
               if (produced == {1'b0, hdr_shift[63:32]})
                  push_beat(8'h00, STATUS_DONE, produced[31:0]);
               else
                  push_beat(8'h00, STATUS_FAIL, 32'd0);
            end else if (33'(pos) > produced) begin
               fail_stop();
            end else if (produced + 33'(cnt) > {1'b0, buf_size}) begin
               fail_stop();
            end else begin
               produced = produced + 33'(cnt);
               for (int i = 0; i < int'(cnt); i++) begin
                  src = wr_ptr - pos[11:0];
                  emit(history[src]);
               end
               next_flag();
            end
         end
      endcase
   endfunction

   // Note one accepted input beat and queue the output beats it causes.
   function void accept_byte(logic [7:0] b, logic start);
      int before_n;
      result_beat_type r;
      if (start)
         restart();
      if (stopped)
         return;
      consumed++;
      before_n = expected_q.size();
      decode_byte(b);
      if (expected_q.size() > before_n) begin
         r = expected_q.pop_back();
         r.last = 1'b1;
         expected_q.push_back(r);
      end
   endfunction

   task report(string msg);
      if (mismatches < 40)
         $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task check_out(logic [39:0] tdata, logic [1:0] tuser, logic tlast);
      result_beat_type e;
      if (expected_q.size() == 0) begin
         report($sformatf("unexpected output beat tdata=%h tuser=%h tlast=%b",
                          tdata, tuser, tlast));
         return;
      end
      e = expected_q.pop_front();
      checked++;
      if (tdata[7:0] !== e.data)
         report($sformatf("beat %0d out_byte %h, want %h", checked, tdata[7:0], e.data));
      if (tuser !== e.status)
         report($sformatf("beat %0d status %0d, want %0d", checked, tuser, e.status));
      if (tdata[39:8] !== e.total)
         report($sformatf("beat %0d total_len %0d, want %0d", checked, tdata[39:8], e.total));
      if (tlast !== e.last)
         report($sformatf("beat %0d last %b, want %b", checked, tlast, e.last));
   endtask
endclass

module testbench;

   localparam int CLK_PERIOD   = 8;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int DRAIN_LIMIT  = 200_000;
   // a 16-byte match may still be copying; leave margin before touching the register
   localparam int SETTLE       = 40;
   localparam int PHASE_ITEMS  = 26;

   typedef enum int {
      K_GOOD, K_WRONG_TOTAL, K_OVERFLOW, K_FAR, K_BAD_HDR, K_RESTART, K_NOISE, K_LONG
   } stream_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [31:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] in_byte
   logic        req_tuser  = 1'b0; // [0] start_req
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;         // [7:0] out_byte, [39:8] total_len
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        rsp_tlast;         // last

   decomp_scoreboard decomp_sb;

   // {start_req, in_byte} of the payload being built, and the tokens of one flag group
   logic [8:0]  payload_q[$];
   logic [8:0]  tok_q[$];
   logic [31:0] cur_buf_size  = '1;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          payloads       = 0;
   int          settings       = 0;
   int          beats_sent     = 0;

   lzss_stream_decompressor_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // Output side: check every accepted beat against the oldest prediction, then
   // pick the next ready value. Signals read here hold their pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         decomp_sb.check_out(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Hard stop in case the block hangs or drops beats.
   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

   // Present one input beat and hold it until accepted. Enter and leave right after
   // a rising edge; leave tvalid high so the next beat can follow back to back.
   task automatic send_byte(logic [7:0] b, logic start);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do
         @(posedge clock);
      while (!req_tready);
      beats_sent++;
      decomp_sb.accept_byte(b, start);
   endtask

   task automatic send_payload();
      foreach (payload_q[i])
         send_byte(payload_q[i][7:0], payload_q[i][8]);
   endtask

   // Drop valid, wait for every predicted beat, then let a running match settle.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      for (int c = 0; c < DRAIN_LIMIT && decomp_sb.expected_q.size() != 0; c++)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_buf_size(logic [31:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      decomp_sb.set_buf_size(v);
      cur_buf_size = v;
      settings++;
      csr_we <= 1'b0;
   endtask

   // Header: id then size, little endian; start rides on the first byte.
   task automatic add_header(logic [31:0] id, logic [31:0] size);
      logic [63:0] hdr;
      hdr = {size, id};
      for (int i = 0; i < 8; i++)
         payload_q.push_back({(i == 0), hdr[8 * i +: 8]});
   endtask

   task automatic push_match(int pos, int len);
      logic [11:0] p;
      p = 12'(pos - 1);
      tok_q.push_back({1'b0, p[11:4]});
      tok_q.push_back({1'b0, p[3:0], 4'(len - 1)});
   endtask

   // Build one payload of the given kind into payload_q. Well-formed streams pick
   // distances that stay inside the bytes produced so far.
   task automatic build_stream(stream_kind_type kind);
      logic [31:0] target;
      logic [31:0] hdr_size;
      logic [31:0] hdr_id;
      logic [7:0]  flag;
      logic [11:0] p12;
      int          produced, room, maxd, len, pos, tok_no, fault_at, cap, lit_pct, keep;
      bit          done;
      payload_q.delete();
      if (kind == K_NOISE) begin
         repeat (12) payload_q.push_back({($urandom_range(0, 7) == 0), 8'($urandom)});
         return;
      end
      cap     = (cur_buf_size < 40) ? int'(cur_buf_size) : 40;
      target  = (cap == 0) ? 32'd1 : $urandom_range(1, cap);
      lit_pct = 50;
      if (kind == K_LONG) begin
         // mostly matches, so long copies run back to back
         target  = 160;
         lit_pct = 5;
      end
      hdr_size = target;
      hdr_id   = LZSS_ID;
      case (kind)
         K_WRONG_TOTAL:
            hdr_size = (target > 1 && $urandom_range(0, 1)) ? target - 1 : target + 1;
         K_OVERFLOW:
            if (cur_buf_size != 0 && cur_buf_size < 200) begin
               hdr_size = cur_buf_size;
               target   = cur_buf_size + $urandom_range(1, 16);
            end
         K_BAD_HDR:
            case ($urandom_range(0, 2))
               0:       hdr_id = LZSS_ID ^ (32'd1 << $urandom_range(0, 31));
               1:       hdr_size = 32'd0;
               default:
                  if (cur_buf_size != '1)
                     hdr_size = cur_buf_size + 32'd1 + ($urandom % (~cur_buf_size));
                  else
                     hdr_id = $urandom;
            endcase
         default: ;
      endcase
      add_header(hdr_id, hdr_size);
      if (kind == K_BAD_HDR) begin
         repeat (2) payload_q.push_back({1'b0, 8'($urandom)});
         return;
      end
      produced = 0;
      done     = 1'b0;
      tok_no   = 0;
      fault_at = (kind == K_FAR) ? $urandom_range(0, 1) : -1;
      while (!done) begin
         // unused flag bits after the end token stay random
         flag = 8'($urandom);
         tok_q.delete();
         for (int i = 0; i < 8 && !done; i++) begin
            room = (kind == K_OVERFLOW) ? 16 : int'(target) - produced;
            maxd = (produced < HIST_DEPTH) ? produced : HIST_DEPTH;
            if (tok_no == fault_at && produced < HIST_DEPTH) begin
               flag[i] = 1'b1;
               push_match($urandom_range(produced + 1, HIST_DEPTH), $urandom_range(2, 16));
               done = 1'b1;
            end else if (produced >= int'(target)) begin
               // end token: length field of zero, distance is don't-care
               flag[i] = 1'b1;
               p12 = 12'($urandom);
               tok_q.push_back({1'b0, p12[11:4]});
               tok_q.push_back({1'b0, p12[3:0], 4'h0});
               done = 1'b1;
            end else if (produced == 0 || room < 2 || $urandom_range(0, 99) < lit_pct) begin
               flag[i] = 1'b0;
               tok_q.push_back({1'b0, 8'($urandom)});
               produced++;
            end else begin
               len = $urandom_range(2, (room < 16) ? room : 16);
               case ($urandom_range(0, 3))
                  0:       pos = $urandom_range(1, (maxd < len) ? maxd : len);  // overlapping
                  1:       pos = maxd;
                  default: pos = $urandom_range(1, maxd);
               endcase
               flag[i] = 1'b1;
               push_match(pos, len);
               produced += len;
            end
            tok_no++;
         end
         payload_q.push_back({1'b0, flag});
         foreach (tok_q[j])
            payload_q.push_back(tok_q[j]);
      end
      if (kind == K_RESTART) begin
         // cut the stream short; the next payload's start restarts the decoder
         keep = $urandom_range(1, payload_q.size() - 1);
         while (payload_q.size() > keep)
            void'(payload_q.pop_back());
      end else begin
         // trailing bytes after a stop must be ignored
         repeat ($urandom_range(0, 2)) payload_q.push_back({1'b0, 8'($urandom)});
      end
   endtask

   function automatic stream_kind_type pick_kind(int ph, int n);
      int r;
      if (ph == 0 && n == 0)
         return K_LONG;
      // walk through every kind first, then favor well-formed streams
      case (n)
         1: return K_GOOD;
         2: return K_WRONG_TOTAL;
         3: return K_OVERFLOW;
         4: return K_FAR;
         5: return K_BAD_HDR;
         6: return K_RESTART;
         7: return K_NOISE;
         default: ;
      endcase
      r = $urandom_range(0, 19);
      if (r < 10) return K_GOOD;
      if (r < 12) return K_WRONG_TOTAL;
      if (r < 14) return K_OVERFLOW;
      if (r < 15) return K_FAR;
      if (r < 17) return K_BAD_HDR;
      if (r < 19) return K_RESTART;
      return K_NOISE;
   endfunction

   initial begin
      logic [31:0] buf_plan [8];
      int          start_count;
      int          n;
      decomp_sb = new();
      buf_plan = '{32'hFFFF_FFFF, 32'd0, 32'd24, 32'd1, 32'h8000_0000, 32'd60, 32'd0, 32'd4096};
      buf_plan[6] = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: bytes before any start are dropped; then a good stream with a
      // literal, an overlapping copy and a matching end token; then a bad id.
      payload_q.delete();
      payload_q.push_back({1'b0, 8'hFF});
      payload_q.push_back({1'b0, 8'h00});
      add_header(LZSS_ID, 32'd3);
      payload_q.push_back({1'b0, 8'h06});   // literal, match, match
      payload_q.push_back({1'b0, 8'hFF});   // literal
      payload_q.push_back({1'b0, 8'h00});   // distance 1 ...
      payload_q.push_back({1'b0, 8'h01});   // ... length 2
      payload_q.push_back({1'b0, 8'hFF});   // end token, top distance
      payload_q.push_back({1'b0, 8'hF0});
      add_header(LZSS_ID ^ 32'h8000_0000, 32'd5);
      send_payload();
      payloads += 2;

      // Random phases: each sets a buffer size and an idle mix, then sends
      // payloads until enough beats have gone in.
      for (int ph = 0; ph < 8; ph++) begin
         quiesce();
         write_buf_size(buf_plan[ph]);
         case (ph % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         start_count = beats_sent;
         n = 0;
         while (beats_sent - start_count < PHASE_ITEMS) begin
            build_stream(pick_kind(ph, n));
            send_payload();
            n++;
            payloads++;
         end
      end

      quiesce();
      if (decomp_sb.expected_q.size() != 0)
         decomp_sb.report($sformatf("%0d predicted beats never arrived",
                                    decomp_sb.expected_q.size()));
      $display("Sent %0d payloads in %0d input beats (%0d decoded), %0d buffer-size settings",
               payloads, beats_sent, decomp_sb.consumed, settings);
      $display("Checked %0d output beats, %0d mismatches",
               decomp_sb.checked, decomp_sb.mismatches);
      if (decomp_sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: lzss_stream_decompressor_core.f
rtl/core/lzssd_pkg.sv
rtl/core/lzssd_ram.sv
rtl/core/lzss_stream_decompressor_core.sv
test/testbench.sv
